>>> src/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants of the BMP byte stream to RGBA converter.
// ----------------------------------------------------------------------------
package bmp_pkg;

    typedef enum logic [3:0] {
        ERR_OK          = 4'd0,
        ERR_TOO_SMALL   = 4'd1,
        ERR_SIGNATURE   = 4'd2,
        ERR_SIZE        = 4'd3,
        ERR_INFO_SIZE   = 4'd4,
        ERR_PALETTE     = 4'd5,
        ERR_COMPRESSION = 4'd6,
        ERR_DEPTH       = 4'd7,
        ERR_TOO_LARGE   = 4'd8
    } t_err;

    // One result as classified by the parser, before channel ordering
    typedef struct packed {
        logic        is_err;
        t_err        err;
        logic        wide;
        logic [23:0] pix;
        logic [7:0]  tail;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_slot;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

>>> src/bmp_in_if.sv
// ----------------------------------------------------------------------------
// bmp_in_if
// Byte channel carrying one BMP file byte per transaction.
// ----------------------------------------------------------------------------
interface bmp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic [31:0] file_length;

    modport source (output valid, output data_byte, output start_of_file,
                    output file_length, input ready);
    modport sink   (input valid, input data_byte, input start_of_file,
                    input file_length, output ready);
endinterface

>>> src/bmp_out_if.sv
// ----------------------------------------------------------------------------
// bmp_out_if
// Pixel channel carrying one RGBA pixel or one error result per transaction.
// ----------------------------------------------------------------------------
interface bmp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] error_code;
    logic       last;

    modport source (output valid, output red, output green, output blue,
                    output alpha, output error_code, output last, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha, input error_code, input last, output ready);
endinterface

>>> src/bmp_stream_to_rgba.sv
// ----------------------------------------------------------------------------
// bmp_stream_to_rgba
// BMP file byte stream to RGBA pixel stream, 24 and 32 bit sources.
//
//   channel   direction  transaction
//   i_bmp     in         one file byte, start flag, file length
//   o_rgba    out        one RGBA pixel or one error result, last flag
//
// One byte is taken every cycle while the result queue has room; each pixel
// passes through a queue entry and then the output register to the output.
// Reset is synchronous and needs no clearing pass; the block is ready as
// soon as reset is released.
// Input ready falls only when the two-entry result queue is full, so a
// stall on the output reaches the input after three held results (one in
// the output register, two queued).
// ----------------------------------------------------------------------------
module bmp_stream_to_rgba
    import bmp_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmp_in_if.sink    i_bmp,
    bmp_out_if.source o_rgba
);

    t_slot push;
    t_slot head;
    logic  q_full;
    logic  pop;

    bmp_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bmp    (i_bmp),
        .i_q_full (q_full),
        .o_push   (push)
    );

    bmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    bmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rgba  (o_rgba)
    );

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> (i_bmp.valid && i_bmp.ready && !q_full))
        else $error("result pushed without an accepted byte");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rgba.valid && o_rgba.error_code != ERR_OK) |->
            (o_rgba.last && o_rgba.alpha == 8'd0 && o_rgba.red == 8'd0))
        else $error("error result not flagged last or not zeroed");

endmodule

>>> src/bmp_front.sv
// ----------------------------------------------------------------------------
// bmp_front
// Header parser, header checks, offset skip, pixel byte gathering and row
// padding skip. Emits one classified result per completed pixel or error.
// ----------------------------------------------------------------------------
module bmp_front
    import bmp_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmp_in_if.sink        i_bmp,
    input  logic          i_q_full,
    output t_slot         o_push
);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_PIXEL  = 6'b001000,
        PH_PAD    = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    localparam int DW = DIM_BITS + 1;
    localparam logic [31:0] MAX_DIM = 32'((64'd1 << DIM_BITS) - 64'd1);

    localparam logic [31:0] HDR_BYTES   = 32'd54;
    localparam logic [31:0] HDR_LAST    = 32'd53;
    localparam logic [5:0]  OFF_FSIZE   = 6'd2;
    localparam logic [5:0]  OFF_OFFSET  = 6'd10;
    localparam logic [5:0]  OFF_INFO    = 6'd14;
    localparam logic [5:0]  OFF_WIDTH   = 6'd18;
    localparam logic [5:0]  OFF_HEIGHT  = 6'd22;
    localparam logic [5:0]  OFF_DEPTH   = 6'd28;
    localparam logic [5:0]  OFF_COMPR   = 6'd30;
    localparam logic [5:0]  OFF_PALETTE = 6'd46;
    localparam logic [15:0] SIG_BM      = 16'h4D42;
    localparam logic [31:0] INFO_SIZE   = 32'd40;
    localparam logic [15:0] DEPTH_24    = 16'd24;
    localparam logic [15:0] DEPTH_32    = 16'd32;

    t_phase              r_phase, n_phase, cur_phase;
    logic [31:0]         r_byte_count, n_byte_count, cur_cnt;
    logic [15:0]         r_sig, n_sig;
    logic [15:0]         r_depth, n_depth;
    logic [31:0]         r_fsize, n_fsize;
    logic [31:0]         r_offset, n_offset;
    logic [31:0]         r_info, n_info;
    logic [31:0]         r_width, n_width;
    logic [31:0]         r_height, n_height;
    logic [31:0]         r_compr, n_compr;
    logic [31:0]         r_palette, n_palette;
    logic [23:0]         r_pix, n_pix;
    logic [1:0]          r_bip, n_bip, cur_bip;
    logic [DIM_BITS-1:0] r_col, n_col, cur_col;
    logic [DIM_BITS-1:0] r_row, n_row, cur_row;
    logic [1:0]          r_pad, n_pad, cur_pad;

    logic       accept;
    logic [5:0] p;
    logic       wide;
    logic       row_end;
    logic       final_px;
    logic       w_pos;
    logic       h_pos;
    t_err       err;

    function automatic logic [31:0] set_lane(logic [31:0] f, logic [1:0] lane,
                                             logic [7:0] b);
        logic [31:0] r;
        r = f;
        r[8*lane +: 8] = b;
        return r;
    endfunction

    assign i_bmp.ready = !i_q_full;
    assign accept      = i_bmp.valid && i_bmp.ready;

    assign cur_phase = i_bmp.start_of_file ? PH_HEADER : r_phase;
    assign cur_cnt   = i_bmp.start_of_file ? '0 : r_byte_count;
    assign cur_bip   = i_bmp.start_of_file ? '0 : r_bip;
    assign cur_col   = i_bmp.start_of_file ? '0 : r_col;
    assign cur_row   = i_bmp.start_of_file ? '0 : r_row;
    assign cur_pad   = i_bmp.start_of_file ? '0 : r_pad;
    assign p         = cur_cnt[5:0];

    assign wide     = (r_depth == DEPTH_32);
    assign w_pos    = (r_width != '0) && !r_width[31];
    assign h_pos    = (r_height != '0) && !r_height[31];
    assign row_end  = (DW'(cur_col) + DW'(1)) >= DW'(r_width[DIM_BITS-1:0]);
    assign final_px = row_end &&
                      ((DW'(cur_row) + DW'(1)) >= DW'(r_height[DIM_BITS-1:0]));

    always_comb begin
        if (r_sig != SIG_BM) begin
            err = ERR_SIGNATURE;
        end else if (r_fsize != i_bmp.file_length) begin
            err = ERR_SIZE;
        end else if (r_info != INFO_SIZE) begin
            err = ERR_INFO_SIZE;
        end else if (r_palette != '0) begin
            err = ERR_PALETTE;
        end else if (r_compr != '0) begin
            err = ERR_COMPRESSION;
        end else if (r_depth != DEPTH_24 && r_depth != DEPTH_32) begin
            err = ERR_DEPTH;
        end else if ((w_pos && r_width > MAX_DIM) || (h_pos && r_height > MAX_DIM)) begin
            err = ERR_TOO_LARGE;
        end else begin
            err = ERR_OK;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_sig        = r_sig;
        n_depth      = r_depth;
        n_fsize      = r_fsize;
        n_offset     = r_offset;
        n_info       = r_info;
        n_width      = r_width;
        n_height     = r_height;
        n_compr      = r_compr;
        n_palette    = r_palette;
        n_pix        = r_pix;
        n_bip        = r_bip;
        n_col        = r_col;
        n_row        = r_row;
        n_pad        = r_pad;
        o_push       = '0;

        if (accept) begin
            n_phase      = cur_phase;
            n_byte_count = cur_cnt;
            n_bip        = cur_bip;
            n_col        = cur_col;
            n_row        = cur_row;
            n_pad        = cur_pad;
            if (i_bmp.start_of_file && i_bmp.file_length <= HDR_BYTES) begin
                o_push.valid      = 1'b1;
                o_push.cmd.is_err = 1'b1;
                o_push.cmd.err    = ERR_TOO_SMALL;
                o_push.cmd.last   = 1'b1;
                n_phase           = PH_DONE;
            end else begin
                if (cur_phase != PH_IDLE && cur_phase != PH_DONE) begin
                    n_byte_count = cur_cnt + 32'd1;
                end
                case (cur_phase)
                    PH_HEADER: begin
                        if (p <= 6'd1) begin
                            n_sig[8*p[0] +: 8] = i_bmp.data_byte;
                        end
                        if (p >= OFF_DEPTH && p <= OFF_DEPTH + 6'd1) begin
                            n_depth[8*p[0] +: 8] = i_bmp.data_byte;
                        end
                        if (p >= OFF_FSIZE && p < OFF_FSIZE + 6'd4) begin
                            n_fsize = set_lane(r_fsize, 2'(p - OFF_FSIZE), i_bmp.data_byte);
                        end
                        if (p >= OFF_OFFSET && p < OFF_OFFSET + 6'd4) begin
                            n_offset = set_lane(r_offset, 2'(p - OFF_OFFSET),
                                                i_bmp.data_byte);
                        end
                        if (p >= OFF_INFO && p < OFF_INFO + 6'd4) begin
                            n_info = set_lane(r_info, 2'(p - OFF_INFO), i_bmp.data_byte);
                        end
                        if (p >= OFF_WIDTH && p < OFF_WIDTH + 6'd4) begin
                            n_width = set_lane(r_width, 2'(p - OFF_WIDTH), i_bmp.data_byte);
                        end
                        if (p >= OFF_HEIGHT && p < OFF_HEIGHT + 6'd4) begin
                            n_height = set_lane(r_height, 2'(p - OFF_HEIGHT),
                                                i_bmp.data_byte);
                        end
                        if (p >= OFF_COMPR && p < OFF_COMPR + 6'd4) begin
                            n_compr = set_lane(r_compr, 2'(p - OFF_COMPR), i_bmp.data_byte);
                        end
                        if (p >= OFF_PALETTE && p < OFF_PALETTE + 6'd4) begin
                            n_palette = set_lane(r_palette, 2'(p - OFF_PALETTE),
                                                 i_bmp.data_byte);
                        end
                        if (cur_cnt == HDR_LAST) begin
                            if (err != ERR_OK) begin
                                o_push.valid      = 1'b1;
                                o_push.cmd.is_err = 1'b1;
                                o_push.cmd.err    = err;
                                o_push.cmd.last   = 1'b1;
                                n_phase           = PH_DONE;
                            end else if (!w_pos || !h_pos) begin
                                n_phase = PH_DONE;
                            end else if (r_offset <= HDR_BYTES) begin
                                n_phase = PH_PIXEL;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (cur_cnt >= r_offset - 32'd1) begin
                            n_phase = PH_PIXEL;
                        end
                    end
                    PH_PIXEL: begin
                        if (cur_bip < (wide ? 2'd3 : 2'd2)) begin
                            case (cur_bip)
                                2'd0:    n_pix[7:0]   = i_bmp.data_byte;
                                2'd1:    n_pix[15:8]  = i_bmp.data_byte;
                                2'd2:    n_pix[23:16] = i_bmp.data_byte;
                                default: n_pix        = r_pix;
                            endcase
                            n_bip = cur_bip + 2'd1;
                        end else begin
                            o_push.valid    = 1'b1;
                            o_push.cmd.err  = ERR_OK;
                            o_push.cmd.wide = wide;
                            o_push.cmd.pix  = r_pix;
                            o_push.cmd.tail = i_bmp.data_byte;
                            o_push.cmd.last = final_px;
                            n_bip           = '0;
                            if (final_px) begin
                                n_phase = PH_DONE;
                            end else if (row_end) begin
                                n_col = '0;
                                n_row = cur_row + DIM_BITS'(1);
                                n_pad = wide ? 2'd0 : r_width[1:0];
                                if (!wide && r_width[1:0] != 2'd0) begin
                                    n_phase = PH_PAD;
                                end
                            end else begin
                                n_col = cur_col + DIM_BITS'(1);
                            end
                        end
                    end
                    PH_PAD: begin
                        n_pad = cur_pad - 2'd1;
                        if (cur_pad == 2'd1) begin
                            n_phase = PH_PIXEL;
                        end
                    end
                    default: begin
                        n_phase = cur_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_count <= '0;
            r_bip        <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_pad        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_bip        <= n_bip;
            r_col        <= n_col;
            r_row        <= n_row;
            r_pad        <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sig     <= n_sig;
        r_depth   <= n_depth;
        r_fsize   <= n_fsize;
        r_offset  <= n_offset;
        r_info    <= n_info;
        r_width   <= n_width;
        r_height  <= n_height;
        r_compr   <= n_compr;
        r_palette <= n_palette;
        r_pix     <= n_pix;
    end

endmodule

>>> src/bmp_queue.sv
// ----------------------------------------------------------------------------
// bmp_queue
// Short register queue between the parser and the output formatter.
// ----------------------------------------------------------------------------
module bmp_queue
    import bmp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_slot i_push,
    input  logic  i_pop,
    output logic  o_full,
    output t_slot o_head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

endmodule

>>> src/bmp_back.sv
// ----------------------------------------------------------------------------
// bmp_back
// Output formatter: orders channels to RGBA, fills alpha and holds the
// result register until the pixel channel takes it.
// ----------------------------------------------------------------------------
module bmp_back
    import bmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_slot     i_head,
    output logic      o_pop,
    bmp_out_if.source o_rgba
);

    logic       r_valid, n_valid;
    logic [7:0] r_red, n_red;
    logic [7:0] r_green, n_green;
    logic [7:0] r_blue, n_blue;
    logic [7:0] r_alpha, n_alpha;
    t_err       r_err, n_err;
    logic       r_last, n_last;

    assign o_pop = i_head.valid && (!r_valid || o_rgba.ready);

    always_comb begin
        n_valid = r_valid;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        n_alpha = r_alpha;
        n_err   = r_err;
        n_last  = r_last;
        if (o_pop) begin
            n_valid = 1'b1;
            n_err   = i_head.cmd.err;
            n_last  = i_head.cmd.last;
            if (i_head.cmd.is_err) begin
                n_red   = '0;
                n_green = '0;
                n_blue  = '0;
                n_alpha = '0;
            end else if (i_head.cmd.wide) begin
                n_red   = i_head.cmd.pix[23:16];
                n_green = i_head.cmd.pix[15:8];
                n_blue  = i_head.cmd.pix[7:0];
                n_alpha = i_head.cmd.tail;
            end else begin
                n_red   = i_head.cmd.tail;
                n_green = i_head.cmd.pix[15:8];
                n_blue  = i_head.cmd.pix[7:0];
                n_alpha = ALPHA_OPAQUE;
            end
        end else if (o_rgba.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_alpha <= n_alpha;
        r_err   <= n_err;
        r_last  <= n_last;
    end

    assign o_rgba.valid      = r_valid;
    assign o_rgba.red        = r_red;
    assign o_rgba.green      = r_green;
    assign o_rgba.blue       = r_blue;
    assign o_rgba.alpha      = r_alpha;
    assign o_rgba.error_code = r_err;
    assign o_rgba.last       = r_last;

endmodule

>>> test/tb_bmp_stream_to_rgba.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_stream_to_rgba
// Feeds generated BMP files, well-formed and broken, one byte per transaction
// into the converter and checks every pixel and error result against a
// byte-level decoder kept in a scoreboard. Both channels idle at random; the
// pixel side is held off for a long stretch once so that the input stalls.
// ----------------------------------------------------------------------------
module tb_bmp_stream_to_rgba;
    import bmp_pkg::*;

    localparam int          DIM_BITS      = 16;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          RANDOM_ITEMS  = 1330;
    localparam int          HEADER_BYTES  = 54;
    localparam logic [31:0] INFO_SIZE     = 32'd40;
    localparam logic [31:0] DEPTH_RGB     = 32'd24;
    localparam logic [31:0] DEPTH_RGBA    = 32'd32;
    localparam logic [15:0] BMP_SIGNATURE = {"M", "B"};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        t_err       error_code;
        logic       last;
    } t_rgba;

    typedef struct {
        logic [7:0]  data;
        logic        sof;
        logic [31:0] len;
    } t_bmp_byte;

    typedef enum int {
        K_RGB, K_RGBA, K_SIGNATURE, K_SIZE, K_INFO, K_PALETTE, K_COMPRESSION,
        K_DEPTH, K_TOO_LARGE, K_NO_PIXELS, K_TOO_SMALL, K_TRUNCATED, K_TRAILING,
        K_NOISE, K_HUGE_LEN, K_COUNT
    } t_file_kind;

    class bmp_pixel_checker;
        typedef enum {PH_IDLE, PH_HEADER, PH_SKIP, PH_PIXEL, PH_PAD, PH_DONE} t_chk_phase;

        t_chk_phase  phase;
        logic [31:0] pos;
        logic [31:0] fld [8];
        logic [23:0] pix_acc;
        int unsigned pix_idx;
        logic [31:0] col;
        logic [31:0] row;
        logic [1:0]  pad;
        t_rgba       pixels_due [$];
        int          errors;

        function new();
            errors = 0;
            phase  = PH_IDLE;
            restart();
        endfunction

        function void restart();
            phase   = PH_IDLE;
            pos     = '0;
            foreach (fld[i]) fld[i] = '0;
            pix_acc = '0;
            pix_idx = 0;
            col     = '0;
            row     = '0;
            pad     = '0;
        endfunction

        function bit is_positive(logic [31:0] v);
            return v != 32'd0 && !v[31];
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        function void take_byte(logic [7:0] data, logic sof, logic [31:0] len);
            t_rgba       px;
            bit          emit;
            bit          wide;
            bit          row_end;
            bit          is_final;
            t_err        err;
            int unsigned p;
            logic [31:0] maxdim;
            px     = '0;
            emit   = 1'b0;
            maxdim = (32'd1 << DIM_BITS) - 32'd1;
            if (sof) begin
                restart();
                phase = PH_HEADER;
                if (len <= HEADER_BYTES) begin
                    px.error_code = ERR_TOO_SMALL;
                    px.last       = 1'b1;
                    pixels_due.push_back(px);
                    phase = PH_DONE;
                    return;
                end
            end
            case (phase)
                PH_HEADER: begin
                    p = pos;
                    if (p <= 1) fld[0][8*p +: 8] = data;
                    else if (p >= 28 && p <= 29) fld[0][16 + 8*(p-28) +: 8] = data;
                    else if (p >= 2 && p <= 5) fld[1][8*(p-2) +: 8] = data;
                    else if (p >= 10 && p <= 13) fld[2][8*(p-10) +: 8] = data;
                    else if (p >= 14 && p <= 17) fld[3][8*(p-14) +: 8] = data;
                    else if (p >= 18 && p <= 21) fld[4][8*(p-18) +: 8] = data;
                    else if (p >= 22 && p <= 25) fld[5][8*(p-22) +: 8] = data;
                    else if (p >= 30 && p <= 33) fld[6][8*(p-30) +: 8] = data;
                    else if (p >= 46 && p <= 49) fld[7][8*(p-46) +: 8] = data;
                    if (p == HEADER_BYTES - 1) begin
                        err = ERR_OK;
                        if (fld[0][15:0] != BMP_SIGNATURE) err = ERR_SIGNATURE;
                        else if (fld[1] != len) err = ERR_SIZE;
                        else if (fld[3] != INFO_SIZE) err = ERR_INFO_SIZE;
                        else if (fld[7] != 32'd0) err = ERR_PALETTE;
                        else if (fld[6] != 32'd0) err = ERR_COMPRESSION;
                        else if ({16'd0, fld[0][31:16]} != DEPTH_RGB &&
                                 {16'd0, fld[0][31:16]} != DEPTH_RGBA) err = ERR_DEPTH;
                        else if ((is_positive(fld[4]) && fld[4] > maxdim) ||
                                 (is_positive(fld[5]) && fld[5] > maxdim))
                            err = ERR_TOO_LARGE;
                        if (err != ERR_OK) begin
                            px.error_code = err;
                            px.last       = 1'b1;
                            emit          = 1'b1;
                            phase         = PH_DONE;
                        end else if (!is_positive(fld[4]) || !is_positive(fld[5])) begin
                            phase = PH_DONE;
                        end else if (fld[2] <= HEADER_BYTES) begin
                            phase = PH_PIXEL;
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (pos >= fld[2] - 32'd1) phase = PH_PIXEL;
                end
                PH_PIXEL: begin
                    wide = {16'd0, fld[0][31:16]} == DEPTH_RGBA;
                    if (pix_idx < (wide ? 3 : 2)) begin
                        pix_acc[8*pix_idx +: 8] = data;
                        pix_idx++;
                    end else begin
                        if (wide) begin
                            px.red   = pix_acc[23:16];
                            px.alpha = data;
                        end else begin
                            px.red   = data;
                            px.alpha = ALPHA_OPAQUE;
                        end
                        px.green   = pix_acc[15:8];
                        px.blue    = pix_acc[7:0];
                        pix_acc    = '0;
                        pix_idx    = 0;
                        row_end    = col + 32'd1 >= fld[4];
                        is_final   = row_end && (row + 32'd1 >= fld[5]);
                        px.last    = is_final;
                        emit       = 1'b1;
                        if (is_final) begin
                            phase = PH_DONE;
                        end else if (row_end) begin
                            col = '0;
                            row = row + 32'd1;
                            pad = wide ? 2'd0 : fld[4][1:0];
                            if (pad != 2'd0) phase = PH_PAD;
                        end else begin
                            col = col + 32'd1;
                        end
                    end
                end
                PH_PAD: begin
                    pad = pad - 2'd1;
                    if (pad == 2'd0) phase = PH_PIXEL;
                end
                default: return;
            endcase
            pos = pos + 32'd1;
            if (emit) pixels_due.push_back(px);
        endfunction

        function void check_pixel(t_rgba got);
            t_rgba      want;
            logic [7:0] want_v [6];
            logic [7:0] got_v [6];
            string      names [6];
            if (pixels_due.size() == 0) begin
                $error("result with nothing expected: rgba %02h %02h %02h %02h err %0d last %0b",
                       got.red, got.green, got.blue, got.alpha, got.error_code, got.last);
                errors++;
                return;
            end
            want   = pixels_due.pop_front();
            names  = '{"red", "green", "blue", "alpha", "error_code", "last"};
            want_v = '{want.red, want.green, want.blue, want.alpha,
                       {4'd0, want.error_code}, {7'd0, want.last}};
            got_v  = '{got.red, got.green, got.blue, got.alpha,
                       {4'd0, got.error_code}, {7'd0, got.last}};
            foreach (names[i]) begin
                if (got_v[i] !== want_v[i]) begin
                    $error("%s: expected %0d, actual %0d", names[i], want_v[i], got_v[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bmp_in_if  bmp_in ();
    bmp_out_if rgba_out ();

    bmp_stream_to_rgba #(
        .DIM_BITS (DIM_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bmp   (bmp_in),
        .o_rgba  (rgba_out)
    );

    bmp_pixel_checker pixel_chk = new();

    t_bmp_byte  byte_q [$];
    logic [7:0] file_hdr [HEADER_BYTES];
    int         items_queued = 0;
    bit         no_idle = 1'b0;
    bit         hold_sink = 1'b0;
    bit         big_image = 1'b0;
    int         stall_cycles = 0;
    t_rgba      seen_px;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic queue_byte(logic [7:0] data, logic sof, logic [31:0] len);
        t_bmp_byte it;
        it.data = data;
        it.sof  = sof;
        it.len  = len;
        byte_q.push_back(it);
        items_queued++;
    endtask

    task automatic put_le(int at, int n, logic [31:0] v);
        int k;
        for (k = 0; k < n; k++) file_hdr[at + k] = v[8*k +: 8];
    endtask

    task automatic build_file(t_file_kind kind);
        logic [31:0] w, h, depth, offset, len, size_fld, info, comp, pal, big;
        logic [15:0] sig;
        int unsigned gap, row_bytes, data_len, n_send, i;
        if (kind == K_TOO_SMALL) begin
            len = $urandom_range(0, 1) ? $urandom_range(0, HEADER_BYTES) : HEADER_BYTES;
            n_send = $urandom_range(1, 5);
            for (i = 0; i < n_send; i++) queue_byte(8'($urandom_range(0, 255)), i == 0, len);
            return;
        end
        if (kind == K_NOISE) begin
            n_send = $urandom_range(5, 30);
            for (i = 0; i < n_send; i++) begin
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                           $urandom_range(0, 1) ? $urandom : $urandom_range(0, 80));
            end
            return;
        end
        depth = $urandom_range(0, 1) ? DEPTH_RGBA : DEPTH_RGB;
        if (kind == K_RGB) depth = DEPTH_RGB;
        if (kind == K_RGBA) depth = DEPTH_RGBA;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        if (big_image) begin
            w = 12;
            h = 3;
        end
        case ($urandom_range(0, 2))
            0:       offset = $urandom_range(0, HEADER_BYTES);
            1:       offset = HEADER_BYTES;
            default: offset = $urandom_range(HEADER_BYTES + 1, 70);
        endcase
        gap       = (offset > HEADER_BYTES) ? offset - HEADER_BYTES : 0;
        row_bytes = (depth == DEPTH_RGBA) ? 4 * w : 3 * w + (w & 3);
        data_len  = row_bytes * h;
        len       = HEADER_BYTES + gap + data_len;
        n_send    = len;
        sig       = BMP_SIGNATURE;
        info      = INFO_SIZE;
        comp      = '0;
        pal       = '0;
        if (kind == K_HUGE_LEN) begin
            len    = 32'hFFFF_FFFF;
            n_send = HEADER_BYTES + gap + $urandom_range(0, data_len);
        end
        size_fld = len;
        case (kind)
            K_SIGNATURE: begin
                sig = $urandom_range(0, 1) ? BMP_SIGNATURE ^ (16'd1 << $urandom_range(0, 15))
                                           : 16'($urandom);
                if (sig == BMP_SIGNATURE) sig = ~sig;
            end
            K_SIZE: size_fld = len ^ (32'd1 << $urandom_range(0, 31));
            K_INFO: begin
                info = $urandom_range(0, 1) ? 32'd108 : $urandom;
                if (info == INFO_SIZE) info = 32'd12;
            end
            K_PALETTE: begin
                pal = $urandom_range(0, 1) ? $urandom_range(1, 256) : $urandom;
                if (pal == 32'd0) pal = 32'd1;
            end
            K_COMPRESSION: begin
                comp = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom;
                if (comp == 32'd0) comp = 32'd3;
            end
            K_DEPTH: begin
                case ($urandom_range(0, 4))
                    0:       depth = 32'd1;
                    1:       depth = 32'd8;
                    2:       depth = 32'd16;
                    3:       depth = 32'hFFFF;
                    default: depth = $urandom_range(0, 16'hFFFF);
                endcase
                if (depth == DEPTH_RGB || depth == DEPTH_RGBA) depth = 32'd0;
            end
            K_TOO_LARGE: begin
                case ($urandom_range(0, 2))
                    0:       big = 32'h0001_0000;
                    1:       big = 32'h7FFF_FFFF;
                    default: big = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
                endcase
                case ($urandom_range(0, 2))
                    0:       w = big;
                    1:       h = big;
                    default: begin
                        w = big;
                        h = 32'h8000_0000 | $urandom;
                    end
                endcase
            end
            K_NO_PIXELS: begin
                big = $urandom_range(0, 1) ? 32'd0 : (32'h8000_0000 | $urandom);
                if ($urandom_range(0, 1)) w = big;
                else h = big;
            end
            K_TRUNCATED: n_send = $urandom_range(1, len - 1);
            K_TRAILING:  n_send = len + $urandom_range(1, 10);
            default: ;
        endcase
        if (kind >= K_SIGNATURE && kind <= K_NO_PIXELS)
            n_send = HEADER_BYTES + $urandom_range(0, 6);
        for (i = 0; i < HEADER_BYTES; i++) file_hdr[i] = 8'($urandom_range(0, 255));
        put_le(0, 2, {16'd0, sig});
        put_le(2, 4, size_fld);
        put_le(10, 4, offset);
        put_le(14, 4, info);
        put_le(18, 4, w);
        put_le(22, 4, h);
        put_le(28, 2, depth);
        put_le(30, 4, comp);
        put_le(46, 4, pal);
        for (i = 0; i < n_send; i++) begin
            queue_byte((i < HEADER_BYTES) ? file_hdr[i] : 8'($urandom_range(0, 255)), i == 0, len);
        end
    endtask

    task automatic send_bytes();
        t_bmp_byte it;
        int        gap;
        while (byte_q.size() != 0) begin
            it  = byte_q.pop_front();
            gap = draw_gap();
            if (gap > 0) begin
                bmp_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            bmp_in.valid         <= 1'b1;
            bmp_in.data_byte     <= it.data;
            bmp_in.start_of_file <= it.sof;
            bmp_in.file_length   <= it.len;
            do @(posedge i_clk); while (!(bmp_in.valid && bmp_in.ready));
        end
    endtask

    task automatic wait_drained();
        bmp_in.valid <= 1'b0;
        do @(posedge i_clk); while (pixel_chk.pending() != 0);
    endtask

    always @(posedge i_clk) begin
        if (bmp_in.valid && bmp_in.ready) begin
            pixel_chk.take_byte(bmp_in.data_byte, bmp_in.start_of_file, bmp_in.file_length);
        end
    end

    always @(posedge i_clk) begin
        if (rgba_out.valid && rgba_out.ready) begin
            seen_px.red        = rgba_out.red;
            seen_px.green      = rgba_out.green;
            seen_px.blue       = rgba_out.blue;
            seen_px.alpha      = rgba_out.alpha;
            seen_px.error_code = t_err'(rgba_out.error_code);
            seen_px.last       = rgba_out.last;
            pixel_chk.check_pixel(seen_px);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (bmp_in.valid && bmp_in.ready) || (rgba_out.valid && rgba_out.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int gap;
        rgba_out.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_sink) begin
                rgba_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_sink = 1'b0;
            end else begin
                gap = draw_gap();
                if (gap > 0) begin
                    rgba_out.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rgba_out.ready <= 1'b1;
            do @(posedge i_clk); while (!(rgba_out.valid && rgba_out.ready));
        end
    end

    initial begin
        int         file_idx;
        int         pick;
        t_file_kind kind;
        i_rst_n              <= 1'b0;
        bmp_in.valid         <= 1'b0;
        bmp_in.data_byte     <= '0;
        bmp_in.start_of_file <= 1'b0;
        bmp_in.file_length   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes before any start, too-small starts, ignored bytes, maximum length
        queue_byte(8'h00, 1'b0, 32'd0);
        queue_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
        queue_byte(8'($urandom_range(0, 255)), 1'b0, $urandom);
        queue_byte(8'hFF, 1'b1, 32'd0);
        queue_byte(8'h00, 1'b0, 32'd0);
        queue_byte(8'h42, 1'b1, 32'd54);
        queue_byte(8'h4D, 1'b0, 32'd54);
        queue_byte(8'h42, 1'b1, 32'd55);
        queue_byte(8'h4D, 1'b0, 32'd55);
        queue_byte(8'h42, 1'b1, 32'hFFFF_FFFF);
        queue_byte(8'h4D, 1'b0, 32'hFFFF_FFFF);
        send_bytes();
        wait_drained();

        file_idx = 0;
        while (items_queued < RANDOM_ITEMS) begin
            no_idle   = ($urandom_range(0, 3) == 0);
            big_image = 1'b0;
            if (file_idx < int'(K_COUNT)) begin
                kind = t_file_kind'(file_idx);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 35) kind = K_RGB;
                else if (pick < 70) kind = K_RGBA;
                else if (pick < 76) kind = K_TRUNCATED;
                else if (pick < 82) kind = K_TRAILING;
                else kind = t_file_kind'($urandom_range(int'(K_SIGNATURE), int'(K_HUGE_LEN)));
            end
            if (file_idx == int'(K_COUNT)) begin
                kind      = K_RGBA;
                big_image = 1'b1;
                no_idle   = 1'b1;
                hold_sink = 1'b1;
            end
            build_file(kind);
            send_bytes();
            if (file_idx % 6 == 5) wait_drained();
            file_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pixel_chk.errors == 0 && pixel_chk.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
src/bmp_pkg.sv
src/bmp_in_if.sv
src/bmp_out_if.sv
src/bmp_front.sv
src/bmp_queue.sv
src/bmp_back.sv
src/bmp_stream_to_rgba.sv
test/tb_bmp_stream_to_rgba.sv
